[rtl/core/caldc_pkg.sv]
// ============================================================================
// caldc_pkg
// Types, constants and calendar helper functions shared by the date counter.
// ============================================================================
package caldc_pkg;

    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;
    localparam int YEAR_W = 14;
    localparam int SER_W  = 22;
    localparam int IDX_W  = 2;

    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

    // Day number of 2000-01-01, the reset date.
    localparam logic [SER_W-1:0] RESET_SERIAL = 22'd730486;

    // y / 100 = (y * 5243) >> 19 and y / 400 = (y * 5243) >> 21 for y up to 9999.
    localparam logic [12:0] RECIP_100 = 13'd5243;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_FWD  = 2'd1,
        OP_BACK = 2'd2,
        OP_DIFF = 2'd3
    } t_op;

    localparam logic [IDX_W-1:0] CFG_START_DAY   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_START_MONTH = 2'd1;
    localparam logic [IDX_W-1:0] CFG_START_YEAR  = 2'd2;

    typedef struct packed {
        logic a;    // load enable of the first normalization stage
        logic b;    // load enable of the second normalization stage
    } t_stage_en;

    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [MON_W-1:0]  month;
        logic [YEAR_W-1:0] year;
        logic [6:0]        year_mod100;
        logic [1:0]        cent_mod4;
        logic [SER_W-1:0]  serial;
    } t_norm_date;

    // Month codes 0 and 13..15 wrap modulo 12, with 0 standing for December.
    function automatic logic [MON_W-1:0] fix_month(input logic [MON_W-1:0] m);
        logic [MON_W-1:0] r;
        case (m)
            4'd0:    r = 4'd12;
            4'd13:   r = 4'd1;
            4'd14:   r = 4'd2;
            4'd15:   r = 4'd3;
            default: r = m;
        endcase
        return r;
    endfunction

    function automatic logic [DAY_W-1:0] days_in_month(input logic [MON_W-1:0] m,
                                                       input logic leap);
        logic [DAY_W-1:0] r;
        case (m)
            4'd2:                     r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  r = 5'd30;
            default:                  r = 5'd31;
        endcase
        return r;
    endfunction

    function automatic logic [8:0] days_before(input logic [MON_W-1:0] m);
        logic [8:0] r;
        case (m)
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/caldc_ifs.sv]
// ============================================================================
// caldc_ifs
// Valid/ready channels of the date counter: items in, results out, config.
// ============================================================================
interface caldc_in_if;
    import caldc_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic [DAY_W-1:0]  other_day;
    logic [MON_W-1:0]  other_month;
    logic [YEAR_W-1:0] other_year;

    modport source (output valid, op, other_day, other_month, other_year, input ready);
    modport sink   (input valid, op, other_day, other_month, other_year, output ready);
endinterface

interface caldc_out_if;
    import caldc_pkg::*;
    logic              valid;
    logic              ready;
    logic [DAY_W-1:0]  cur_day;
    logic [MON_W-1:0]  cur_month;
    logic [YEAR_W-1:0] cur_year;
    logic [SER_W-1:0]  day_difference;
    logic              at_limit;

    modport source (output valid, cur_day, cur_month, cur_year, day_difference, at_limit,
                    input ready);
    modport sink   (input valid, cur_day, cur_month, cur_year, day_difference, at_limit,
                    output ready);
endinterface

interface caldc_cfg_if;
    import caldc_pkg::*;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  idx;
    logic [YEAR_W-1:0] data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

[rtl/core/caldc_date_norm.sv]
// ============================================================================
// caldc_date_norm
// Two-stage date normalizer: clamps the fields and computes the day number.
// ============================================================================
module caldc_date_norm (
    input  logic                     i_clk,
    input  caldc_pkg::t_stage_en     i_en,
    input  logic [caldc_pkg::DAY_W-1:0]  i_day,
    input  logic [caldc_pkg::MON_W-1:0]  i_month,
    input  logic [caldc_pkg::YEAR_W-1:0] i_year,
    output caldc_pkg::t_norm_date    o_date
);
    import caldc_pkg::*;

    // First stage: clamp year, wrap month, start the constant multiplications.
    logic [YEAR_W-1:0] w_year_c;
    logic [DAY_W-1:0]  r_day_a;
    logic [MON_W-1:0]  r_month_a;
    logic [YEAR_W-1:0] r_year_a;
    logic [25:0]       r_prod_a;
    logic [SER_W-1:0]  r_y365_a;

    assign w_year_c = (i_year > YEAR_MAX) ? YEAR_MAX : i_year;

    always_ff @(posedge i_clk) begin
        if (i_en.a) begin
            r_day_a   <= i_day;
            r_month_a <= fix_month(i_month);
            r_year_a  <= w_year_c;
            r_prod_a  <= 26'(27'(w_year_c) * 27'(RECIP_100));
            r_y365_a  <= 22'(23'(w_year_c) * 23'd365);
        end
    end

    // Second stage: leap rule, day check and the day-number sum.
    logic [6:0]        w_q100;
    logic [4:0]        w_q400;
    logic [6:0]        w_mod100;
    logic              w_leap;
    logic [11:0]       w_leaps;
    logic [DAY_W-1:0]  w_dim;
    logic [DAY_W-1:0]  w_day;
    logic [SER_W-1:0]  w_serial;

    always_comb begin
        w_q100   = r_prod_a[25:19];
        w_q400   = r_prod_a[25:21];
        w_mod100 = 7'(r_year_a - 14'(w_q100) * 14'd100);
        w_leap   = (w_mod100 == 7'd0) ? (w_q100[1:0] == 2'd0) : (r_year_a[1:0] == 2'd0);
        // Leap years from year 0 through this one; the current year only
        // counts once February is over.
        w_leaps  = 12'(r_year_a[13:2]) - 12'(w_q100) + 12'(w_q400) + 12'd1
                   - 12'((r_month_a <= 4'd2) && w_leap);
        w_dim    = days_in_month(r_month_a, w_leap);
        w_day    = (r_day_a == 5'd0 || r_day_a > w_dim) ? 5'd1 : r_day_a;
        w_serial = r_y365_a + 22'(w_leaps) + 22'(days_before(r_month_a)) + 22'(w_day);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.b) begin
            o_date.day         <= w_day;
            o_date.month       <= r_month_a;
            o_date.year        <= r_year_a;
            o_date.year_mod100 <= w_mod100;
            o_date.cent_mod4   <= w_q100[1:0];
            o_date.serial      <= w_serial;
        end
    end

endmodule

[rtl/core/calendar_date_counter.sv]
// Items pass the input, normalizer and output registers in order.
// Throughput: one item per cycle unless the output stalls; the held date,
// its day number and its leap-rule counters update at once in the last stage.
// The start date is normalized continuously from the configuration registers.
// Reset (synchronous, active low) empties the pipeline and sets the held
// date and the start date to 2000-01-01.
// ============================================================================
// calendar_date_counter
// Gregorian date counter: load, step forward/back, and day difference.
// ============================================================================
module calendar_date_counter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    caldc_in_if.sink    i_in,
    caldc_out_if.source o_out,
    caldc_cfg_if.sink   i_cfg
);
    import caldc_pkg::*;

    // ---------------- configuration ----------------
    logic [DAY_W-1:0]  r_start_day;
    logic [MON_W-1:0]  r_start_month;
    logic [YEAR_W-1:0] r_start_year;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_day   <= 5'd1;
            r_start_month <= 4'd1;
            r_start_year  <= 14'd2000;
        end else if (i_cfg.valid) begin
            case (i_cfg.idx)
                CFG_START_DAY:   r_start_day   <= i_cfg.data[DAY_W-1:0];
                CFG_START_MONTH: r_start_month <= i_cfg.data[MON_W-1:0];
                CFG_START_YEAR:  r_start_year  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    t_norm_date w_start;

    caldc_date_norm u_start_norm (
        .i_clk   (i_clk),
        .i_en    ('{a: 1'b1, b: 1'b1}),
        .i_day   (r_start_day),
        .i_month (r_start_month),
        .i_year  (r_start_year),
        .o_date  (w_start)
    );

    // ---------------- pipeline control ----------------
    logic r_v0, r_v1, r_v2, r_ov;
    logic w_load_out, w_take2, w_take1, w_take0;

    assign w_load_out = r_v2 && (!r_ov || o_out.ready);
    assign w_take2    = !r_v2 || w_load_out;
    assign w_take1    = !r_v1 || w_take2;
    assign w_take0    = !r_v0 || w_take1;
    assign i_in.ready = w_take0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_take0) r_v0 <= i_in.valid;
            if (w_take1) r_v1 <= r_v0;
            if (w_take2) r_v2 <= r_v1;
            if (w_load_out)       r_ov <= 1'b1;
            else if (o_out.ready) r_ov <= 1'b0;
        end
    end

    // ---------------- input register ----------------
    t_op               r_op0, r_op1, r_op2;
    logic [DAY_W-1:0]  r_oday0;
    logic [MON_W-1:0]  r_omon0;
    logic [YEAR_W-1:0] r_oyear0;

    always_ff @(posedge i_clk) begin
        if (w_take0) begin
            r_op0    <= t_op'(i_in.op);
            r_oday0  <= i_in.other_day;
            r_omon0  <= i_in.other_month;
            r_oyear0 <= i_in.other_year;
        end
        if (w_take1) r_op1 <= r_op0;
        if (w_take2) r_op2 <= r_op1;
    end

    t_norm_date w_other;

    caldc_date_norm u_other_norm (
        .i_clk   (i_clk),
        .i_en    ('{a: w_take1, b: w_take2}),
        .i_day   (r_oday0),
        .i_month (r_omon0),
        .i_year  (r_oyear0),
        .o_date  (w_other)
    );

    // ---------------- held date and result stage ----------------
    logic [DAY_W-1:0]  r_held_day, n_held_day;
    logic [MON_W-1:0]  r_held_month, n_held_month;
    logic [YEAR_W-1:0] r_held_year, n_held_year;
    logic [SER_W-1:0]  r_held_ser, n_held_ser;
    logic [6:0]        r_ymod100, n_ymod100;
    logic [1:0]        r_cent4, n_cent4;
    logic [SER_W-1:0]  n_diff;
    logic              n_limit;
    logic              w_leap;
    logic [DAY_W-1:0]  w_dim;
    logic [MON_W-1:0]  w_prev_month;

    assign w_leap       = (r_ymod100 == 7'd0) ? (r_cent4 == 2'd0) : (r_ymod100[1:0] == 2'd0);
    assign w_dim        = days_in_month(r_held_month, w_leap);
    assign w_prev_month = (r_held_month <= 4'd1) ? 4'd12 : r_held_month - 4'd1;

    always_comb begin
        n_held_day   = r_held_day;
        n_held_month = r_held_month;
        n_held_year  = r_held_year;
        n_held_ser   = r_held_ser;
        n_ymod100    = r_ymod100;
        n_cent4      = r_cent4;
        n_diff       = '0;
        n_limit      = 1'b0;
        case (r_op2)
            OP_LOAD: begin
                n_held_day   = w_start.day;
                n_held_month = w_start.month;
                n_held_year  = w_start.year;
                n_held_ser   = w_start.serial;
                n_ymod100    = w_start.year_mod100;
                n_cent4      = w_start.cent_mod4;
            end
            OP_FWD: begin
                if (r_held_year >= YEAR_MAX && r_held_month == 4'd12 && r_held_day >= 5'd31) begin
                    n_limit = 1'b1;
                end else begin
                    n_held_ser = r_held_ser + 22'd1;
                    if (r_held_day >= w_dim) begin
                        n_held_day = 5'd1;
                        if (r_held_month >= 4'd12) begin
                            n_held_month = 4'd1;
                            n_held_year  = r_held_year + 14'd1;
                            if (r_ymod100 == 7'd99) begin
                                n_ymod100 = 7'd0;
                                n_cent4   = r_cent4 + 2'd1;
                            end else begin
                                n_ymod100 = r_ymod100 + 7'd1;
                            end
                        end else begin
                            n_held_month = r_held_month + 4'd1;
                        end
                    end else begin
                        n_held_day = r_held_day + 5'd1;
                    end
                end
            end
            OP_BACK: begin
                if (r_held_year == 14'd0 && r_held_month == 4'd1 && r_held_day <= 5'd1) begin
                    n_limit = 1'b1;
                end else begin
                    n_held_ser = r_held_ser - 22'd1;
                    if (r_held_day <= 5'd1) begin
                        n_held_month = w_prev_month;
                        // December is 31 days whatever the year, so the
                        // current year's leap flag serves for the new month.
                        n_held_day   = days_in_month(w_prev_month, w_leap);
                        if (r_held_month <= 4'd1) begin
                            n_held_year = r_held_year - 14'd1;
                            if (r_ymod100 == 7'd0) begin
                                n_ymod100 = 7'd99;
                                n_cent4   = r_cent4 - 2'd1;
                            end else begin
                                n_ymod100 = r_ymod100 - 7'd1;
                            end
                        end
                    end else begin
                        n_held_day = r_held_day - 5'd1;
                    end
                end
            end
            OP_DIFF: begin
                n_diff = (r_held_ser > w_other.serial) ? r_held_ser - w_other.serial
                                                       : w_other.serial - r_held_ser;
            end
            default: ;
        endcase
    end

    logic [DAY_W-1:0]  r_o_day;
    logic [MON_W-1:0]  r_o_month;
    logic [YEAR_W-1:0] r_o_year;
    logic [SER_W-1:0]  r_o_diff;
    logic              r_o_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_day   <= 5'd1;
            r_held_month <= 4'd1;
            r_held_year  <= 14'd2000;
            r_held_ser   <= RESET_SERIAL;
            r_ymod100    <= 7'd0;
            r_cent4      <= 2'd0;
        end else if (w_load_out) begin
            r_held_day   <= n_held_day;
            r_held_month <= n_held_month;
            r_held_year  <= n_held_year;
            r_held_ser   <= n_held_ser;
            r_ymod100    <= n_ymod100;
            r_cent4      <= n_cent4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_day   <= n_held_day;
            r_o_month <= n_held_month;
            r_o_year  <= n_held_year;
            r_o_diff  <= n_diff;
            r_o_limit <= n_limit;
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.cur_day        = r_o_day;
    assign o_out.cur_month      = r_o_month;
    assign o_out.cur_year       = r_o_year;
    assign o_out.day_difference = r_o_diff;
    assign o_out.at_limit       = r_o_limit;

    // ---------------- assertions ----------------
    a_limit_at_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_limit) |->
            ((r_o_year == YEAR_MAX && r_o_month == 4'd12 && r_o_day == 5'd31) ||
             (r_o_year == 14'd0 && r_o_month == 4'd1 && r_o_day == 5'd1)))
        else $error("at_limit reported away from the ends of the date range");

    a_held_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held_day >= 5'd1 && r_held_month >= 4'd1 && r_held_month <= 4'd12 &&
         r_held_year <= YEAR_MAX && r_ymod100 <= 7'd99))
        else $error("held date or year counters out of range");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v0 && r_v1 && r_v2 && r_ov && !o_out.ready) |-> !i_in.ready)
        else $error("input accepted while every stage is full and stalled");

    a_year_step_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(w_load_out) && $past(r_op2) == OP_FWD &&
         r_held_year != $past(r_held_year)) |-> (r_held_month == 4'd1 && r_held_day == 5'd1))
        else $error("year advanced without landing on the first of January");

endmodule
